// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/edf_pkg.sv =====
// ---------------------------------------------------------------------------
// edf_pkg
// Shared types and constants of the EDF periodic task scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

    // stream beats
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;
    localparam int TICK_OUT_W = 32;

    // action codes carried on the input tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // configuration port
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int NUM_TASKS_W   = 5;
    localparam int REG_NUM_TASKS = 0;

    // input tdata layout, lowest bits last in the list
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] rel_deadline;
        logic [15:0] exec_time;
        logic [15:0] period;
        logic [3:0]  task_index;
    } t_load_beat;

    // output tdata layout
    typedef struct packed {
        logic        pad;
        logic        overflow;
        logic [31:0] tick_time;
        logic        switched;
        logic        idle;
        logic [3:0]  chosen_task;
    } t_result_beat;

    // control from the sequencer to the scan datapath
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

endpackage

`default_nettype wire

// ===== rtl/edf_periodic_task_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// edf_periodic_task_scheduler_unit
// Tick-driven earliest-deadline-first scheduler for periodic tasks.
// ---------------------------------------------------------------------------
// The task table sits in one RAM with one write and one registered read port.
// A load beat (tuser = 0) writes one entry. A tick beat
// (tuser = 1) walks the active entries one per cycle, releasing due jobs,
// writing each entry back and tracking the earliest deadline, then writes
// back the chosen task's decremented work and posts one result beat. The
// single RAM read port visits each active entry once per tick. The result
// sits in an output register, so the next beat is taken while it waits; a
// finished tick stalls only if the previous result has not been taken yet.
// No clearing pass after reset.
`default_nettype none

module edf_periodic_task_scheduler_unit #(
    parameter int NUM_TASKS  = 16,
    parameter int TIME_BITS  = 32,
    parameter int PARAM_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // task_index[3:0], period[19:4], exec_time[35:20], rel_deadline[51:36]
    input  logic [edf_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // action[0]
    input  logic                             i_s_tuser,
    // master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // chosen_task[3:0], idle[4], switched[5], tick_time[37:6], overflow[38]
    output logic [edf_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [edf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [edf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [edf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import edf_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = $clog2(NUM_TASKS);
    localparam int CW = (IW + 1 > NUM_TASKS_W) ? IW + 1 : NUM_TASKS_W;
    localparam int XW = (IW > 4) ? IW : 4;
    localparam int EW = 4 * PARAM_BITS + 2 * TIME_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    t_load_beat             beat;
    t_result_beat           res;
    t_scan_ctl              ctl;

    logic [NUM_TASKS_W-1:0] num_tasks;
    logic [CW-1:0]          nt_ext, active, load_idx;
    logic                   in_acc, out_free, load_ok, fin, time_max;
    logic [IW-1:0]          load_addr;
    logic [PARAM_BITS-1:0]  ld_per, ld_exe, ld_rel;
    logic [EW-1:0]          load_word;

    logic                   ram_we, ram_re;
    logic [IW-1:0]          ram_waddr, ram_raddr;
    logic [EW-1:0]          ram_wdata, ram_rdata;

    logic [EW-1:0]          scan_wdata, scan_best_wdata;
    logic                   scan_sat, scan_found, sw;
    logic [IW-1:0]          scan_best;
    logic [XW-1:0]          best_ext;

    logic [1:0]             r_state, n_state;
    logic [IW-1:0]          r_cnt, n_cnt;
    logic [NUM_TASKS-1:0]   r_loaded;
    logic [TIME_BITS-1:0]   r_time;
    logic                   r_ovf, n_ovf;
    logic [IW-1:0]          r_prev_task;
    logic                   r_prev_idle;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    edf_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_num_tasks (num_tasks)
    );

    assign beat     = t_load_beat'(i_s_tdata);
    assign nt_ext   = CW'(num_tasks);
    assign active   = (nt_ext > CW'(NUM_TASKS)) ? CW'(NUM_TASKS) : nt_ext;
    assign load_idx = CW'(beat.task_index);
    assign load_ok  = (load_idx < CW'(NUM_TASKS));
    assign load_addr = load_idx[IW-1:0];

    assign ld_per    = PARAM_BITS'(beat.period);
    assign ld_exe    = PARAM_BITS'(beat.exec_time);
    assign ld_rel    = PARAM_BITS'(beat.rel_deadline);
    // fresh entry: no work, released at time 0, deadline = relative deadline
    assign load_word = {ld_rel, ld_exe, ld_per, TIME_BITS'(ld_rel),
                        {TIME_BITS{1'b0}}, {PARAM_BITS{1'b0}}};

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    edf_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    edf_scan #(
        .IW         (IW),
        .TIME_BITS  (TIME_BITS),
        .PARAM_BITS (PARAM_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_idx        (r_cnt),
        .i_loaded     (r_loaded[r_cnt]),
        .i_rdata      (ram_rdata),
        .i_time       (r_time),
        .o_wdata      (scan_wdata),
        .o_sat        (scan_sat),
        .o_found      (scan_found),
        .o_best_idx   (scan_best),
        .o_best_wdata (scan_best_wdata)
    );

    // sequencer: read entry k while entry k-1 is written back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = scan_wdata;
        ram_re    = 1'b0;
        ram_raddr = '0;
        ctl       = '0;
        fin       = 1'b0;
        n_state   = r_state;
        n_cnt     = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_s_tuser == ACT_LOAD) begin
                        ram_we    = load_ok;
                        ram_waddr = load_addr;
                        ram_wdata = load_word;
                    end else begin
                        ctl.clear = 1'b1;
                        ram_re    = 1'b1;
                        n_cnt     = '0;
                        n_state   = (active == '0) ? S_FIN : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ctl.step = 1'b1;
                ram_we   = 1'b1;
                if (CW'(r_cnt) + CW'(1) < active) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_cnt + IW'(1);
                    n_cnt     = r_cnt + IW'(1);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    fin       = 1'b1;
                    n_state   = S_IDLE;
                    ram_we    = scan_found;
                    ram_waddr = scan_best;
                    ram_wdata = scan_best_wdata;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign time_max = (r_time == '1);
    assign n_ovf    = r_ovf || (ctl.step && scan_sat) || (fin && time_max);
    assign best_ext = XW'(scan_best);
    assign sw       = scan_found ? (r_prev_idle || (scan_best != r_prev_task))
                                 : !r_prev_idle;

    always_comb begin
        res             = '0;
        res.chosen_task = scan_found ? best_ext[3:0] : 4'd0;
        res.idle        = !scan_found;
        res.switched    = sw;
        res.tick_time   = TICK_OUT_W'(r_time);
        res.overflow    = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_loaded    <= '0;
            r_time      <= '0;
            r_ovf       <= 1'b0;
            r_prev_task <= '0;
            r_prev_idle <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            if (in_acc && (i_s_tuser == ACT_LOAD) && load_ok) begin
                r_loaded[load_addr] <= 1'b1;
            end
            if (fin) begin
                r_time      <= time_max ? r_time : r_time + TIME_BITS'(1);
                r_prev_idle <= !scan_found;
                r_prev_task <= scan_found ? scan_best : '0;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out_data <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `ASSERT_CLK(a_fin_writeback, i_clk, i_rst_n, (r_state == S_FIN && out_free && scan_found) |-> (ram_we && ram_waddr == scan_best), "chosen task work not written back")
    `ASSERT_CLK(a_tick_starts, i_clk, i_rst_n, (in_acc && i_s_tuser == ACT_TICK) |=> (r_state != S_IDLE), "tick beat did not start a scan")
    `ASSERT_CLK(a_result_from_fin, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_FIN), "result posted outside finish step")
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, (r_state == S_SCAN) && (CW'(r_cnt) >= active), "scan index beyond active entries")

endmodule

`default_nettype wire

// ===== rtl/edf_ram.sv =====
// ---------------------------------------------------------------------------
// edf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module edf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/edf_apb_regs.sv =====
// ---------------------------------------------------------------------------
// edf_apb_regs
// APB register file: holds the number of scheduled task entries.
// ---------------------------------------------------------------------------
`default_nettype none

module edf_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [edf_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [edf_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [edf_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [edf_pkg::NUM_TASKS_W-1:0]   o_num_tasks
);
    import edf_pkg::*;

    localparam int RIW = CFG_ADDR_W - 2;

    logic                   hit;
    logic [NUM_TASKS_W-1:0] r_num_tasks;

    assign hit = (paddr[CFG_ADDR_W-1:2] == RIW'(REG_NUM_TASKS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_tasks <= NUM_TASKS_W'(1);
        end else if (psel && penable && pwrite && hit) begin
            r_num_tasks <= pwdata[NUM_TASKS_W-1:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = hit ? CFG_DATA_W'(r_num_tasks) : '0;
    assign o_num_tasks = r_num_tasks;

endmodule

`default_nettype wire

// ===== rtl/edf_scan.sv =====
// ---------------------------------------------------------------------------
// edf_scan
// Per-entry release update and running earliest-deadline selection.
// ---------------------------------------------------------------------------
`default_nettype none

module edf_scan #(
    parameter int IW         = 4,
    parameter int TIME_BITS  = 32,
    parameter int PARAM_BITS = 16,
    localparam int EW = 4 * PARAM_BITS + 2 * TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  edf_pkg::t_scan_ctl    i_ctl,
    input  logic [IW-1:0]         i_idx,
    input  logic                  i_loaded,
    input  logic [EW-1:0]         i_rdata,
    input  logic [TIME_BITS-1:0]  i_time,
    output logic [EW-1:0]         o_wdata,
    output logic                  o_sat,
    output logic                  o_found,
    output logic [IW-1:0]         o_best_idx,
    output logic [EW-1:0]         o_best_wdata
);
    import edf_pkg::*;

    localparam int P  = PARAM_BITS;
    localparam int T  = TIME_BITS;
    localparam int SW = ((T > P) ? T : P) + 1;

    // entry fields, remaining work in the lowest bits
    logic [P-1:0]  e_rem, e_per, e_exe, e_rel, rem_in, rem_u;
    logic [T-1:0]  e_nrel, e_adl, nrel_sat, adl_sat, nrel_u, adl_u;
    logic [SW-1:0] sum_rel, sum_dl;
    logic          sat_rel, sat_dl, due, better;

    logic          r_found;
    logic [IW-1:0] r_best_idx;
    logic [EW-1:0] r_best_entry;
    logic [T-1:0]  r_best_adl;

    assign e_rem  = i_rdata[P-1:0];
    assign e_nrel = i_rdata[P +: T];
    assign e_adl  = i_rdata[P+T +: T];
    assign e_per  = i_rdata[P+2*T +: P];
    assign e_exe  = i_rdata[2*P+2*T +: P];
    assign e_rel  = i_rdata[3*P+2*T +: P];

    // never-loaded entries read as no remaining work
    assign rem_in = i_loaded ? e_rem : '0;
    assign due    = (e_nrel == i_time);

    assign sum_rel  = SW'(e_nrel) + SW'(e_per);
    assign sum_dl   = SW'(i_time) + SW'(e_rel);
    assign sat_rel  = |sum_rel[SW-1:T];
    assign sat_dl   = |sum_dl[SW-1:T];
    assign nrel_sat = sat_rel ? '1 : sum_rel[T-1:0];
    assign adl_sat  = sat_dl ? '1 : sum_dl[T-1:0];

    assign rem_u  = due ? e_exe : rem_in;
    assign nrel_u = due ? nrel_sat : e_nrel;
    assign adl_u  = due ? adl_sat : e_adl;
    assign o_sat  = due && (sat_rel || sat_dl);

    assign o_wdata = {e_rel, e_exe, e_per, adl_u, nrel_u, rem_u};

    // strict compare in ascending order keeps the lowest index on ties
    assign better = (rem_u != '0) && (!r_found || (adl_u < r_best_adl));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.step && better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && better) begin
            r_best_idx   <= i_idx;
            r_best_entry <= o_wdata;
            r_best_adl   <= adl_u;
        end
    end

    assign o_found      = r_found;
    assign o_best_idx   = r_best_idx;
    assign o_best_wdata = {r_best_entry[EW-1:P], r_best_entry[P-1:0] - P'(1)};

endmodule

`default_nettype wire
